### hdl/wavetable_channel_mixer_top_defines.svh
// Assertion helpers used by wavetable_channel_mixer_top.sv.
`ifndef WAVETABLE_CHANNEL_MIXER_TOP_DEFINES_SVH
`define WAVETABLE_CHANNEL_MIXER_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define WTMIX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WTMIX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/wtmix_pkg.sv
package wtmix_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int TABLE_SIZE   = 64;
  localparam int PHASE_W      = 14;
  localparam int STEP_W       = 13;
  localparam int VOL_W        = 7;
  localparam int LEVEL_W      = 16;
  localparam int SAMPLE_W     = 16;
  localparam int ACC_W        = 18;
  localparam int DIVD_W       = 19;
  localparam int DIVS_W       = 15;
  localparam logic [DIVD_W-1:0] STEP_NUM = 19'd474400;
  localparam logic [6:0] NOTE_MAX = 7'd84;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [STEP_W-1:0]  step;
    logic [VOL_W-1:0]   vol;
    logic               act;
  } chan_t;

  // Ramp: rising 0..255, 0 at index 32, then rising from -248 back toward 0.
  function automatic logic signed [9:0] ramp_at(input logic [5:0] idx);
    logic signed [10:0] v;
    v = $signed({1'b0, idx, 3'b000});
    if (idx < 6'd31) return v[9:0];
    else if (idx == 6'd31) return 10'sd255;
    else if (idx == 6'd32) return 10'sd0;
    else return 10'(v - 11'sd512);
  endfunction

  // Ten times the semitone period at the top octave.
  function automatic logic [DIVS_W-1:0] per10_at(input logic [3:0] semi);
    logic [DIVS_W-1:0] r;
    case (semi)
      4'd0:    r = 15'd10240;
      4'd1:    r = 15'd10850;
      4'd2:    r = 15'd11490;
      4'd3:    r = 15'd12180;
      4'd4:    r = 15'd12900;
      4'd5:    r = 15'd13670;
      4'd6:    r = 15'd14480;
      4'd7:    r = 15'd15340;
      4'd8:    r = 15'd16250;
      4'd9:    r = 15'd17220;
      4'd10:   r = 15'd18250;
      4'd11:   r = 15'd19330;
      default: r = 15'd10240;
    endcase
    return r;
  endfunction

endpackage

### hdl/wavetable_channel_mixer_top.sv
// Wavetable channel mixer.
// Input stream: each request is a set-channel (in_tuser = 0) or a sample tick
// (in_tuser = 1). A set-channel request writes volume, active flag and a phase
// step for one channel and gives no output; channels at or above CHANNELS are
// ignored. A tick gives one mixed, saturated sample on the output stream,
// with out_tuser flagging a clipped sum.
// Set-channel: the note period is divided into the step numerator by a
// restoring divider, one bit a cycle, giving 19 quotient bits; the step is
// then written to the channel cell as the block returns to idle.
// Tick: the channel ring rotates once through the shared voice unit, one
// channel a cycle; the sum then passes the voice unit's stage registers and
// the flush state, and the next request is taken once the result is loaded.
// One request is in flight at a time; in_tready is high only when idle.
// A finished sample waits in the output register; if the receiver stalls
// and a new tick completes, the block holds until that register is free.
// cfg_wr_en writes the envelope level at any edge; write it only when idle.
// Reset (rst_n low, synchronous) clears all channel state, the level goes to
// 65535, and the output register is emptied.
`include "wavetable_channel_mixer_top_defines.svh"

module wavetable_channel_mixer_top #(
  parameter int CHANNELS = wtmix_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // channel_index[3:0], note_number[10:4],
                                  // volume[17:11], active[18], zero[23:19]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // sample[15:0]
  output logic        out_tuser,  // saturated
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data // envelope_level
);

  localparam int CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_MIX   = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0] in_ch;
  logic [6:0] in_note, in_vol, note_c;
  logic       in_act, in_acc;

  assign in_ch   = in_tdata[3:0];
  assign in_note = in_tdata[10:4];
  assign in_vol  = in_tdata[17:11];
  assign in_act  = in_tdata[18];
  assign in_acc  = in_tvalid && in_tready;

  // level register
  logic [15:0] level_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 16'hffff;
    end else if (cfg_wr_en) begin
      level_r <= cfg_wr_data;
    end
  end

  // note -> period: n = 120 - note, octave = n / 12 via reciprocal
  logic [6:0]  n_v;
  logic [14:0] n_mul;
  logic [3:0]  oct, semi;
  logic [7:0]  oct12;
  logic [14:0] per;

  assign note_c = (in_note > wtmix_pkg::NOTE_MAX) ? wtmix_pkg::NOTE_MAX : in_note;
  assign n_v    = 7'd120 - note_c;
  assign n_mul  = n_v * 8'd171;
  assign oct    = n_mul[14:11];
  assign oct12  = oct * 4'd12;
  assign semi   = 4'(n_v - oct12[6:0]);
  assign per    = wtmix_pkg::per10_at(semi) >> (oct - 4'd3);

  logic        set_ok;
  logic        div_start, div_done;
  logic [18:0] div_q;

  assign set_ok    = (32'(in_ch) < CHANNELS);
  assign div_start = in_acc && (in_tuser == wtmix_pkg::CMD_SET) && set_ok;

  wtmix_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (per),
    .done     (div_done),
    .quotient (div_q)
  );

  // pending write data
  logic [3:0] wr_ch_r;
  logic [6:0] wr_vol_r;
  logic       wr_act_r;
  always_ff @(posedge clk) begin
    if (div_start) begin
      wr_ch_r  <= in_ch;
      wr_vol_r <= in_vol;
      wr_act_r <= in_act;
    end
  end

  wtmix_pkg::chan_t wr_data;
  always_comb begin
    wr_data       = '0;
    wr_data.step  = div_q[12:0];
    wr_data.vol   = wr_vol_r;
    wr_data.act   = wr_act_r;
  end

  // channel ring: cell 0 feeds the voice unit, its update re-enters at the tail
  wtmix_pkg::chan_t cell_q [CHANNELS];
  wtmix_pkg::chan_t head_nxt;
  logic             shift_en;

  assign shift_en = (state_r == ST_MIX);

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    wtmix_pkg::chan_t nbr;
    if (i == CHANNELS - 1) begin : g_tail
      assign nbr = head_nxt;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    wtmix_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .nbr_in   (nbr),
      .wr_en    (div_done && (32'(wr_ch_r) == i)),
      .wr_data  (wr_data),
      .st_out   (cell_q[i])
    );
  end

  logic signed [17:0] sum;
  logic               acc_clr;

  assign acc_clr = in_acc && (in_tuser == wtmix_pkg::CMD_TICK);

  wtmix_voice u_voice (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (shift_en),
    .acc_clr   (acc_clr),
    .head      (cell_q[0]),
    .level     (level_r),
    .head_nxt  (head_nxt),
    .sum       (sum)
  );

  // output register state
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_data_r, sat_val;
  logic        out_sat_r, sat_hit;

  // sequencer
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_free, load_out;

  assign out_free = !out_valid_r || out_tready;
  assign load_out = (state_r == ST_DONE) && out_free;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == wtmix_pkg::CMD_TICK) begin
            state_nxt = ST_MIX;
            cnt_nxt   = '0;
          end else if (set_ok) begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_IDLE;
      end
      ST_MIX: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CHANNELS - 1)) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  // saturation and output register
  always_comb begin
    sat_hit = 1'b0;
    sat_val = sum[15:0];
    if (sum > 18'sd32767) begin
      sat_val = 16'h7fff;
      sat_hit = 1'b1;
    end else if (sum < -18'sd32768) begin
      sat_val = 16'h8000;
      sat_hit = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= sat_val;
      out_sat_r  <= sat_hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  `WTMIX_ASSERT_NOW(a_sat_rail, out_tvalid && out_tuser,
    out_tdata == 16'h7fff || out_tdata == 16'h8000, "clip flag without rail value")
  `WTMIX_ASSERT_NOW(a_div_state, div_done, state_r == ST_DIV,
    "divider finished outside set-channel")
  `WTMIX_ASSERT_NEXT(a_tick_start, in_acc && in_tuser == wtmix_pkg::CMD_TICK,
    state_r == ST_MIX && cnt_r == '0, "tick did not start ring walk")

endmodule

### hdl/wtmix_cell.sv
module wtmix_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  wtmix_pkg::chan_t  nbr_in,
  input  logic              wr_en,
  input  wtmix_pkg::chan_t  wr_data,
  output wtmix_pkg::chan_t  st_out
);

  wtmix_pkg::chan_t st_r, st_nxt;

  always_comb begin
    st_nxt = st_r;
    if (shift_en) begin
      st_nxt = nbr_in;
    end else if (wr_en) begin
      st_nxt.step = wr_data.step;
      st_nxt.vol  = wr_data.vol;
      st_nxt.act  = wr_data.act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule

### hdl/wtmix_voice.sv
module wtmix_voice (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    sample_en,
  input  logic                                    acc_clr,
  input  wtmix_pkg::chan_t                        head,
  input  logic [wtmix_pkg::LEVEL_W-1:0]           level,
  output wtmix_pkg::chan_t                        head_nxt,
  output logic signed [wtmix_pkg::ACC_W-1:0]      sum
);

  logic                  live;
  logic [5:0]            idx, idx1;
  logic [7:0]            frac;
  logic signed [9:0]     a_v, n_v, d_v, b_v;
  logic signed [18:0]    dprod;
  logic [22:0]           gain_full;
  logic signed [17:0]    bprod;
  logic signed [17:0]    bshift;

  logic                  s1_valid_r, s1_live_r;
  logic signed [9:0]     s1_b_r;
  logic [6:0]            s1_gain_r;
  logic signed [wtmix_pkg::ACC_W-1:0] acc_r, acc_nxt;

  assign live = head.act && (head.vol != '0);
  assign idx  = head.phase[13:8];
  assign idx1 = idx + 6'd1;
  assign frac = head.phase[7:0];
  assign a_v  = wtmix_pkg::ramp_at(idx);
  assign n_v  = wtmix_pkg::ramp_at(idx1);
  assign d_v  = n_v - a_v;
  assign dprod = d_v * $signed({1'b0, frac});
  assign b_v   = a_v + 10'(dprod >>> 8);
  assign gain_full = head.vol * level;

  always_comb begin
    head_nxt = head;
    if (live) begin
      head_nxt.phase = head.phase + wtmix_pkg::PHASE_W'(head.step);
    end
  end

  // stage 1: interpolated value and gain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= sample_en;
    end
  end

  always_ff @(posedge clk) begin
    s1_b_r    <= b_v;
    s1_gain_r <= gain_full[22:16];
    s1_live_r <= live;
  end

  // stage 2: scale and accumulate
  assign bprod  = s1_b_r * $signed({1'b0, s1_gain_r});
  assign bshift = bprod >>> 4;

  always_comb begin
    acc_nxt = acc_r;
    if (acc_clr) begin
      acc_nxt = '0;
    end else if (s1_valid_r && s1_live_r) begin
      acc_nxt = acc_r + wtmix_pkg::ACC_W'(bshift);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign sum = acc_r;

endmodule

### hdl/wtmix_div.sv
module wtmix_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [wtmix_pkg::DIVS_W-1:0]     divisor,
  output logic                             done,
  output logic [wtmix_pkg::DIVD_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(wtmix_pkg::DIVD_W + 1);

  logic [wtmix_pkg::DIVS_W:0]   rem_r, rem_nxt, trial;
  logic [wtmix_pkg::DIVD_W-1:0] quo_r, quo_nxt;
  logic [wtmix_pkg::DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt, done_r, done_nxt;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r[wtmix_pkg::DIVS_W-1:0], quo_r[wtmix_pkg::DIVD_W-1]};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = wtmix_pkg::STEP_NUM;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(wtmix_pkg::DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[wtmix_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[wtmix_pkg::DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
